// File: design/mbrs_pkg.sv
// Shared constants, types and functions for the Modbus RTU register slave.
`timescale 1ns / 1ps
`default_nettype none
package mbrs_pkg;
  localparam int unsigned NumRegsDefault = 8;
  localparam logic [7:0] SlaveAddrReset = 8'd3;
  localparam logic [7:0] FnRead = 8'h03;
  localparam logic [7:0] FnWrite = 8'h10;
  localparam logic [7:0] FnExcFlag = 8'h80;
  localparam logic [7:0] ExcAddress = 8'h02;
  localparam logic [7:0] ExcValue = 8'h03;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Bytewise reflected CRC-16 update; eight narrow steps.
  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (x[0]) x = (x >> 1) ^ CrcPoly;
      else x = x >> 1;
    end
    return x;
  endfunction
endpackage
`default_nettype wire

// File: design/mbrs_if.sv
// Valid/ready stream interfaces for request and response bytes.
`timescale 1ns / 1ps
`default_nettype none
interface mbrs_rx_if;
  logic valid;
  logic ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mbrs_tx_if;
  logic valid;
  logic ready;
  logic [7:0] tx_byte;
  logic last_byte;
  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink (input valid, input tx_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// File: design/modbus_rtu_register_slave.sv
// Modbus RTU holding-register slave: frame parser, register memory and responder.
// Each request byte is absorbed as it arrives; a frame-closing byte with good CRC starts a
// response of up to 2*NUM_REGS+5 bytes (8 for a write): header and CRC bytes one per cycle
// unless the output stalls, each register's two bytes after its memory read, and for a
// write, a first pass copying each buffered word into memory. No new request byte is taken
// while a response is built. Synchronous active-low reset clears control state; a pass
// clears all NUM_REGS entries of register memory and write buffer before any byte is taken.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_register_slave #(
  parameter int unsigned NUM_REGS = mbrs_pkg::NumRegsDefault
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic [7:0] cfg_wdata,
  mbrs_rx_if.sink in_ch,
  mbrs_tx_if.source out_ch
);
  localparam int unsigned AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned BW = AW + 1;
  localparam int unsigned BufBytes = 2 * NUM_REGS;

  typedef enum logic [2:0] {
    S_CLEAR, S_RX, S_WRITE, S_HEAD, S_RDREQ, S_RDHI, S_RDLO, S_CRC
  } state_t;

  state_t state_r;
  logic [7:0] slave_addr_r;
  logic [8:0] pos_r;
  logic [15:0] crc_r, tx_crc_r;
  logic is_write_r;
  logic [15:0] start_r, count_r;
  logic [7:0] dbc_r;
  logic [7:0] exc_r;
  logic [AW-1:0] clr_r;
  logic [15:0] idx_r;
  logic [2:0] hcnt_r;
  logic crc_hi_r;
  logic [7:0] out_byte_r;
  logic out_last_r, out_valid_r;
  logic [7:0] rd_hold_r;

  // Register memory, and the write-data buffer split into high/low byte banks.
  logic [15:0] regs_mem [NUM_REGS];
  logic [7:0] buf_hi [NUM_REGS];
  logic [7:0] buf_lo [NUM_REGS];
  logic [15:0] reg_rd_r;
  logic [7:0] bhi_rd_r, blo_rd_r;

  logic in_fire, out_free;
  logic [7:0] b;
  logic [15:0] crc_in, crc_nxt;
  logic [8:0] k;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [15:0] wr_data;
  logic wr_en;
  logic [16:0] end_addr;

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_RX);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign b = in_ch.rx_byte;
  assign crc_in = (pos_r == 9'd0) ? mbrs_pkg::CrcInit : crc_r;
  assign crc_nxt = mbrs_pkg::crc_update(crc_in, b);
  assign k = pos_r - 9'd7;
  assign end_addr = {1'b0, start_r} + {1'b0, count_r};
  assign out_ch.valid = out_valid_r;
  assign out_ch.tx_byte = out_byte_r;
  assign out_ch.last_byte = out_last_r;

  // Memory address select: clear sweep while clearing, start plus register index otherwise.
  always_comb begin
    rd_addr = idx_r[AW-1:0] + start_r[AW-1:0];
    wr_addr = (state_r == S_CLEAR) ? clr_r : rd_addr;
    wr_data = (state_r == S_CLEAR) ? 16'h0000 : {bhi_rd_r, blo_rd_r};
    wr_en = (state_r == S_CLEAR) || (state_r == S_WRITE && hcnt_r[0]);
  end

  // Register memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) regs_mem[wr_addr] <= wr_data;
    reg_rd_r <= regs_mem[rd_addr];
  end

  // Write buffer: stored by the parser, read back during the write pass.
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      buf_hi[clr_r] <= 8'h00;
      buf_lo[clr_r] <= 8'h00;
    end else if (in_fire && is_write_r && pos_r >= 9'd7 && k < {1'b0, dbc_r}
                 && k < 9'(BufBytes)) begin
      if (k[0]) buf_lo[k[BW-1:1]] <= b;
      else buf_hi[k[BW-1:1]] <= b;
    end
    bhi_rd_r <= buf_hi[idx_r[AW-1:0]];
    blo_rd_r <= buf_lo[idx_r[AW-1:0]];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) slave_addr_r <= mbrs_pkg::SlaveAddrReset;
    else if (cfg_we) slave_addr_r <= cfg_wdata;
  end

  // Parser and responder sequencer.
  always_ff @(posedge clk) begin
    logic done;
    logic [7:0] ob;
    logic ol, emit;
    logic [8:0] pos_v;
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      pos_r <= '0;
      crc_r <= mbrs_pkg::CrcInit;
      is_write_r <= 1'b0;
      start_r <= '0;
      count_r <= '0;
      dbc_r <= '0;
      out_valid_r <= 1'b0;
      out_last_r <= 1'b0;
      idx_r <= '0;
      hcnt_r <= '0;
      crc_hi_r <= 1'b0;
    end else begin
      done = 1'b0;
      ob = 8'h00;
      ol = 1'b0;
      emit = 1'b0;
      pos_v = pos_r;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(NUM_REGS - 1)) state_r <= S_RX;
        end
        S_RX: begin
          if (in_fire) begin
            crc_r <= crc_nxt;
            pos_v = pos_r + 9'd1;
            case (pos_r)
              9'd0: if (b != slave_addr_r) pos_v = 9'd0;
              9'd1: begin
                if (b == mbrs_pkg::FnRead) is_write_r <= 1'b0;
                else if (b == mbrs_pkg::FnWrite) is_write_r <= 1'b1;
                else pos_v = 9'd0;
              end
              9'd2: start_r[15:8] <= b;
              9'd3: start_r[7:0] <= b;
              9'd4: count_r[15:8] <= b;
              9'd5: count_r[7:0] <= b;
              9'd6: if (is_write_r) dbc_r <= b;
              default: begin
                if (!is_write_r) done = 1'b1;
                else if (k > {1'b0, dbc_r}) done = 1'b1;
              end
            endcase
            if (done) begin
              pos_v = 9'd0;
              idx_r <= '0;
              hcnt_r <= '0;
              crc_hi_r <= 1'b0;
              if (crc_nxt == 16'h0000) begin
                if (start_r >= 16'(NUM_REGS)) begin
                  exc_r <= mbrs_pkg::ExcAddress;
                  state_r <= S_HEAD;
                end else if (count_r == 16'h0000 || end_addr > 17'(NUM_REGS)) begin
                  exc_r <= mbrs_pkg::ExcValue;
                  state_r <= S_HEAD;
                end else if (is_write_r && {8'h00, dbc_r} != {count_r[14:0], 1'b0}) begin
                  exc_r <= mbrs_pkg::ExcValue;
                  state_r <= S_HEAD;
                end else begin
                  exc_r <= 8'h00;
                  state_r <= is_write_r ? S_WRITE : S_HEAD;
                end
              end
            end
            pos_r <= pos_v;
          end
        end
        S_WRITE: begin
          // even phase: buffer read; odd phase: memory write
          hcnt_r[0] <= ~hcnt_r[0];
          if (hcnt_r[0]) begin
            if (idx_r + 16'd1 == count_r) begin
              idx_r <= '0;
              state_r <= S_HEAD;
            end else idx_r <= idx_r + 16'd1;
          end
        end
        S_HEAD: begin
          if (out_free) begin
            emit = 1'b1;
            hcnt_r <= hcnt_r + 3'd1;
            if (hcnt_r == 3'd0) ob = slave_addr_r;
            else if (exc_r != 8'h00) begin
              ob = (hcnt_r == 3'd1)
                ? ((is_write_r ? mbrs_pkg::FnWrite : mbrs_pkg::FnRead) | mbrs_pkg::FnExcFlag)
                : exc_r;
              if (hcnt_r == 3'd2) state_r <= S_CRC;
            end else if (!is_write_r) begin
              ob = (hcnt_r == 3'd1) ? mbrs_pkg::FnRead : {count_r[6:0], 1'b0};
              if (hcnt_r == 3'd2) state_r <= S_RDREQ;
            end else begin
              case (hcnt_r)
                3'd1: ob = mbrs_pkg::FnWrite;
                3'd2: ob = start_r[15:8];
                3'd3: ob = start_r[7:0];
                3'd4: ob = count_r[15:8];
                default: begin
                  ob = count_r[7:0];
                  state_r <= S_CRC;
                end
              endcase
            end
          end
        end
        S_RDREQ: state_r <= S_RDHI;
        S_RDHI: begin
          if (out_free) begin
            emit = 1'b1;
            ob = reg_rd_r[15:8];
            rd_hold_r <= reg_rd_r[7:0];
            state_r <= S_RDLO;
          end
        end
        S_RDLO: begin
          if (out_free) begin
            emit = 1'b1;
            ob = rd_hold_r;
            if (idx_r + 16'd1 == count_r) state_r <= S_CRC;
            else begin
              idx_r <= idx_r + 16'd1;
              state_r <= S_RDREQ;
            end
          end
        end
        S_CRC: begin
          if (out_free) begin
            emit = 1'b1;
            crc_hi_r <= 1'b1;
            if (!crc_hi_r) ob = tx_crc_r[7:0];
            else begin
              ob = tx_crc_r[15:8];
              ol = 1'b1;
              state_r <= S_RX;
            end
          end
        end
        default: state_r <= S_RX;
      endcase
      // output register: load a new byte, or drop valid once the held byte is taken
      if (emit) begin
        out_valid_r <= 1'b1;
        out_byte_r <= ob;
        out_last_r <= ol;
        if (state_r != S_CRC) begin
          tx_crc_r <= mbrs_pkg::crc_update(
            (state_r == S_HEAD && hcnt_r == 3'd0) ? mbrs_pkg::CrcInit : tx_crc_r, ob);
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// File: bench/tb_if.sv
// Bench helper package: the expected response byte type.
`timescale 1ns / 1ps
package tb_frame_pkg;
  // one expected response byte
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } resp_byte_t;
endpackage

// File: bench/testbench.sv
// Self-checking bench for the Modbus RTU register slave: frames in, predicted responses out.
`timescale 1ns / 1ps
module testbench;
  localparam int NREGS = mbrs_pkg::NumRegsDefault;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;

  mbrs_rx_if rx_ch ();
  mbrs_tx_if tx_ch ();

  modbus_rtu_register_slave #(.NUM_REGS(NREGS)) u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(rx_ch.sink), .out_ch(tx_ch.source)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  my_addr;
  logic [8:0]  pos;
  logic [15:0] rx_crc;
  logic        wr_req;
  logic [15:0] start_reg;
  logic [15:0] reg_cnt;
  logic [7:0]  byte_cnt;
  logic [7:0]  wbuf [2*NREGS];
  logic [15:0] regs [NREGS];
  tb_frame_pkg::resp_byte_t pending_resp [$];

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
    return x;
  endfunction

  // emit one predicted response byte
  logic [15:0] tx_crc;
  task automatic push_resp(input logic [7:0] b);
    pending_resp.push_back('{tx_byte: b, last_byte: 1'b0});
    tx_crc = crc_byte(tx_crc, b);
  endtask

  task automatic build_response();
    logic [7:0] fn;
    logic [7:0] exc;
    logic [15:0] c;
    fn = wr_req ? mbrs_pkg::FnWrite : mbrs_pkg::FnRead;
    exc = 8'd0;
    tx_crc = mbrs_pkg::CrcInit;
    push_resp(my_addr);
    if (start_reg >= NREGS) exc = mbrs_pkg::ExcAddress;
    else if (reg_cnt == 0 || reg_cnt > NREGS - start_reg) exc = mbrs_pkg::ExcValue;
    else if (wr_req && {8'd0, byte_cnt} != 2 * reg_cnt) exc = mbrs_pkg::ExcValue;
    if (exc != 0) begin
      push_resp(fn | mbrs_pkg::FnExcFlag);
      push_resp(exc);
    end else if (!wr_req) begin
      push_resp(fn);
      push_resp(8'(2 * reg_cnt));
      for (int i = 0; i < reg_cnt; i++) begin
        push_resp(regs[start_reg + i][15:8]);
        push_resp(regs[start_reg + i][7:0]);
      end
    end else begin
      for (int i = 0; i < reg_cnt; i++) regs[start_reg + i] = {wbuf[2*i], wbuf[2*i+1]};
      push_resp(fn);
      push_resp(start_reg[15:8]);
      push_resp(start_reg[7:0]);
      push_resp(reg_cnt[15:8]);
      push_resp(reg_cnt[7:0]);
    end
    c = tx_crc;
    push_resp(c[7:0]);
    push_resp(c[15:8]);
    pending_resp[$].last_byte = 1'b1;
  endtask

  // advance the frame tracker by one accepted request byte
  task automatic track_byte(input logic [7:0] b);
    int k;
    logic done;
    done = 1'b0;
    if (pos == 0) rx_crc = mbrs_pkg::CrcInit;
    rx_crc = crc_byte(rx_crc, b);
    case (pos)
      0: begin if (b == my_addr) pos = 9'd1; return; end
      1: begin
        if (b == mbrs_pkg::FnRead) begin wr_req = 1'b0; pos = 9'd2; end
        else if (b == mbrs_pkg::FnWrite) begin wr_req = 1'b1; pos = 9'd2; end
        else pos = 9'd0;
        return;
      end
      2: begin start_reg[15:8] = b; pos = 9'd3; return; end
      3: begin start_reg[7:0] = b; pos = 9'd4; return; end
      4: begin reg_cnt[15:8] = b; pos = 9'd5; return; end
      5: begin reg_cnt[7:0] = b; pos = 9'd6; return; end
      6: begin if (wr_req) byte_cnt = b; pos = 9'd7; return; end
      default: ;
    endcase
    if (!wr_req) done = 1'b1;
    else begin
      k = pos - 7;
      if (k < byte_cnt && k < 2*NREGS) wbuf[k] = b;
      if (k <= byte_cnt) pos = 9'(pos + 1);
      else done = 1'b1;
    end
    if (done) begin
      pos = 9'd0;
      if (rx_crc == 0) build_response();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] exp);
    $display("mismatch %s: got %02h expected %02h at %0t", what, got, exp, $time);
    errors++;
  endtask

  // drive one request transaction; valid stays up until the next one or an idle cycle
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    track_byte(b);
  endtask

  // response checker and receiver stalls
  always @(posedge clk) begin
    if (rst_n && tx_ch.valid && tx_ch.ready) begin
      if (pending_resp.size() == 0) begin
        report_mismatch("unexpected byte", tx_ch.tx_byte, 8'h00);
      end else begin
        tb_frame_pkg::resp_byte_t e;
        e = pending_resp.pop_front();
        if (tx_ch.tx_byte !== e.tx_byte) report_mismatch("tx_byte", tx_ch.tx_byte, e.tx_byte);
        if (tx_ch.last_byte !== e.last_byte)
          report_mismatch("last_byte", {7'd0, tx_ch.last_byte}, {7'd0, e.last_byte});
      end
    end
    tx_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_frame(input logic [7:0] bytes [$], input bit good_crc);
    logic [15:0] c;
    c = mbrs_pkg::CrcInit;
    foreach (bytes[i]) begin
      send_byte(bytes[i]);
      c = crc_byte(c, bytes[i]);
    end
    if (!good_crc) c ^= 16'(1 << $urandom_range(15));
    send_byte(c[7:0]);
    send_byte(c[15:8]);
  endtask

  task automatic read_frame(input logic [7:0] a, input logic [15:0] st, input logic [15:0] n,
                            input bit good);
    logic [7:0] f [$];
    f = '{a, mbrs_pkg::FnRead, st[15:8], st[7:0], n[15:8], n[7:0]};
    send_frame(f, good);
  endtask

  task automatic write_frame(input logic [7:0] a, input logic [15:0] st, input logic [15:0] n,
                             input logic [7:0] bc, input bit good);
    logic [7:0] f [$];
    f = '{a, mbrs_pkg::FnWrite, st[15:8], st[7:0], n[15:8], n[7:0], bc};
    for (int i = 0; i < bc; i++) f.push_back(8'($urandom));
    send_frame(f, good);
  endtask

  // release the request channel, wait for all responses, then let the block settle
  task automatic drain();
    rx_ch.valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_address(input logic [7:0] a);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_we <= 1'b0;
    my_addr = a;
  endtask

  task automatic test_directed();
    read_frame(my_addr, 16'd0, 16'(NREGS), 1'b1);
    write_frame(my_addr, 16'd0, 16'(NREGS), 8'(2*NREGS), 1'b1);
    read_frame(my_addr, 16'd0, 16'(NREGS), 1'b1);
    read_frame(my_addr, 16'hFFFF, 16'd1, 1'b1);
    read_frame(my_addr, 16'd2, 16'd0, 1'b1);
    read_frame(my_addr, 16'd2, 16'hFFFF, 1'b1);
    write_frame(my_addr, 16'd1, 16'd2, 8'd3, 1'b1);
    write_frame(my_addr, 16'd7, 16'd1, 8'd2, 1'b0);
    write_frame(my_addr, 16'd0, 16'd1, 8'd40, 1'b1);
    send_byte(8'h00);
    send_byte(my_addr);
    send_byte(8'h55);
    read_frame(8'(my_addr + 1), 16'd0, 16'd1, 1'b1);
    read_frame(my_addr, 16'd7, 16'd1, 1'b1);
  endtask

  task automatic test_random(input int frames);
    logic [15:0] st, n;
    int kind;
    for (int f = 0; f < frames; f++) begin
      kind = $urandom_range(9);
      st = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(NREGS));
      n = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(NREGS));
      if (kind < 4) read_frame(my_addr, st, n, $urandom_range(9) != 0);
      else if (kind < 8)
        write_frame(my_addr, st, n,
                    ($urandom_range(7) == 0) ? 8'($urandom_range(40)) : 8'(2 * n),
                    $urandom_range(9) != 0);
      else if (kind == 8) read_frame(8'($urandom), st, n, 1'b1);
      else send_byte(8'($urandom));
    end
  endtask

  initial begin
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = 8'd0;
    my_addr = mbrs_pkg::SlaveAddrReset;
    pos = 9'd0; rx_crc = mbrs_pkg::CrcInit; wr_req = 1'b0;
    start_reg = 16'd0; reg_cnt = 16'd0; byte_cnt = 8'd0;
    foreach (wbuf[i]) wbuf[i] = 8'd0;
    foreach (regs[i]) regs[i] = 16'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    set_address(8'd1);
    send_idle_pct = 57; test_random(8);
    set_address(8'd247);
    send_idle_pct = 0; recv_stall_pct = 57; test_random(8);
    set_address(8'd0);
    send_idle_pct = 30; recv_stall_pct = 30; test_random(6);
    set_address(8'hFF);
    send_idle_pct = 0; recv_stall_pct = 0; test_random(5);
    set_address(8'($urandom_range(1, 246)));
    test_random(4);
    drain();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
